### hdl/pscd_pkg.sv
// Shared types and constants for the point-segment closest distance core.
`timescale 1ns / 1ps
package pscd_pkg;
	typedef enum logic [1:0] {
		REG_DEGEN    = 2'd0,
		REG_CLAMP_A  = 2'd1,
		REG_CLAMP_B  = 2'd2,
		REG_INTERIOR = 2'd3
	} region_t;

	localparam int DSQ_WIDTH  = 33;
	localparam int DRES_WIDTH = 17;
	localparam int IN_BYTES   = 12;
	localparam int OUT_BYTES  = 11;
endpackage

### hdl/point_segment_closest_distance_core.sv
// Top level: pipelined closest point on a segment, squared distance and its root.
`timescale 1ns / 1ps
// Takes one transfer per clock unless the master side stalls, and returns one result per item, in order.
// The pipeline holds six stages for differences, products, sums and region
// choice, d*t products, rounding and squares, T_FRAC_BITS restoring divider
// stages that produce one quotient bit each, and 17 square-root stages that
// produce one root bit each, the last of which is the output register. A stall
// on the master side halts the entire pipeline in place; nothing is dropped or
// repeated.
module point_segment_closest_distance_core #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// ax, ay, bx, by_coord, px, py (16 bits each, signed)
	input  logic [pscd_pkg::IN_BYTES*8-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// qx[15:0], qy[31:16], dist_sq[64:32], dist_res[81:65], region[83:82], zero fill
	output logic [pscd_pkg::OUT_BYTES*8-1:0]    m_tdata
);
	import pscd_pkg::*;

	localparam int CW  = 16;
	localparam int SW  = 2*CW + 2;      // s, dot magnitude bits incl. sign
	localparam int TW  = T_FRAC_BITS;
	localparam int NDV = TW;
	localparam int NSQ = DRES_WIDTH;
	localparam int NST = 6 + NDV + NSQ;

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic [NST-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end
	assign m_tvalid = vld_q[NST-1];

	// stage 1: differences
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, px_s1, py_s1;
	logic signed [CW:0]   dx_s1, dy_s1, wx_s1, wy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= s_tdata[15:0];   ay_s1 <= s_tdata[31:16];
			bx_s1 <= s_tdata[47:32];  by_s1 <= s_tdata[63:48];
			px_s1 <= s_tdata[79:64];  py_s1 <= s_tdata[95:80];
			dx_s1 <= $signed({s_tdata[47], s_tdata[47:32]}) - $signed({s_tdata[15], s_tdata[15:0]});
			dy_s1 <= $signed({s_tdata[63], s_tdata[63:48]}) - $signed({s_tdata[31], s_tdata[31:16]});
			wx_s1 <= $signed({s_tdata[79], s_tdata[79:64]}) - $signed({s_tdata[15], s_tdata[15:0]});
			wy_s1 <= $signed({s_tdata[95], s_tdata[95:80]}) - $signed({s_tdata[31], s_tdata[31:16]});
		end
	end

	// stage 2: products
	logic signed [CW-1:0] ax_s2, ay_s2, bx_s2, by_s2, px_s2, py_s2;
	logic signed [CW:0]   dx_s2, dy_s2;
	logic signed [2*CW+1:0] pxx_s2, pyy_s2, pwx_s2, pwy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2 <= ax_s1; ay_s2 <= ay_s1; bx_s2 <= bx_s1; by_s2 <= by_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; dx_s2 <= dx_s1; dy_s2 <= dy_s1;
			pxx_s2 <= dx_s1 * dx_s1; pyy_s2 <= dy_s1 * dy_s1;
			pwx_s2 <= dx_s1 * wx_s1; pwy_s2 <= dy_s1 * wy_s1;
		end
	end

	// stage 3: sums and region choice
	logic signed [SW-1:0] s_sum, dot_sum;
	assign s_sum   = SW'(pxx_s2) + SW'(pyy_s2);
	assign dot_sum = SW'(pwx_s2) + SW'(pwy_s2);

	logic signed [CW-1:0] ax_s3, ay_s3, bx_s3, by_s3, px_s3, py_s3;
	logic signed [CW:0]   dx_s3, dy_s3;
	logic [SW-1:0]        s_s3, dot_s3;
	region_t              reg_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3 <= ax_s2; ay_s3 <= ay_s2; bx_s3 <= bx_s2; by_s3 <= by_s2;
			px_s3 <= px_s2; py_s3 <= py_s2; dx_s3 <= dx_s2; dy_s3 <= dy_s2;
			s_s3 <= s_sum; dot_s3 <= dot_sum;
			if (s_sum == '0)                 reg_s3 <= REG_DEGEN;
			else if (dot_sum <= 0)           reg_s3 <= REG_CLAMP_A;
			else if (dot_sum >= s_sum)       reg_s3 <= REG_CLAMP_B;
			else                             reg_s3 <= REG_INTERIOR;
		end
	end

	// divider stages: one quotient bit per stage, remainder stays below s
	typedef struct packed {
		logic signed [CW-1:0] ax, ay, bx, by, px, py;
		logic signed [CW:0]   dx, dy;
		logic [SW-1:0]        s, rem;
		logic [TW-1:0]        quo;
		logic [1:0]           rg;
	} dv_t;
	dv_t dv_in;
	always_comb begin
		dv_in.ax = ax_s3; dv_in.ay = ay_s3; dv_in.bx = bx_s3; dv_in.by = by_s3;
		dv_in.px = px_s3; dv_in.py = py_s3; dv_in.dx = dx_s3; dv_in.dy = dy_s3;
		dv_in.s = s_s3; dv_in.quo = '0; dv_in.rg = reg_s3;
		dv_in.rem = (reg_s3 == REG_INTERIOR) ? dot_s3 : '0;
	end
	dv_t dv_q [NDV];
	for (genvar g = 0; g < NDV; g++) begin : g_div
		dv_t         src, nxt;
		logic [SW:0] sh;
		logic        ge;
		if (g == 0) begin : g_head
			assign src = dv_in;
		end else begin : g_body
			assign src = dv_q[g-1];
		end
		assign sh = {src.rem, 1'b0};
		assign ge = sh >= {1'b0, src.s};
		always_comb begin
			nxt     = src;
			nxt.rem = ge ? SW'(sh - {1'b0, src.s}) : SW'(sh);
			nxt.quo = {src.quo[TW-2:0], ge};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_q[g] <= nxt;
			end
		end
	end

	// stage 4: d*t products
	localparam int PW = CW + TW + 2;
	dv_t dl;
	assign dl = dv_q[NDV-1];
	logic signed [PW-1:0] mx_s4, my_s4;
	logic signed [CW-1:0] ax_s4, ay_s4, bx_s4, by_s4, px_s4, py_s4;
	logic [1:0]           rg_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s4 <= PW'(dl.dx * $signed({1'b0, dl.quo}));
			my_s4 <= PW'(dl.dy * $signed({1'b0, dl.quo}));
			ax_s4 <= dl.ax; ay_s4 <= dl.ay; bx_s4 <= dl.bx; by_s4 <= dl.by;
			px_s4 <= dl.px; py_s4 <= dl.py; rg_s4 <= dl.rg;
		end
	end

	// stage 5: round, select Q, error vector
	logic signed [PW-1:0] rx, ry;
	logic signed [CW-1:0] qx_c, qy_c;
	assign rx = (mx_s4 + (PW'(1) <<< (TW-1))) >>> TW;
	assign ry = (my_s4 + (PW'(1) <<< (TW-1))) >>> TW;
	always_comb begin
		case (region_t'(rg_s4))
			REG_CLAMP_B:  begin qx_c = bx_s4; qy_c = by_s4; end
			REG_INTERIOR: begin qx_c = ax_s4 + CW'(rx); qy_c = ay_s4 + CW'(ry); end
			default:      begin qx_c = ax_s4; qy_c = ay_s4; end
		endcase
	end
	logic signed [CW-1:0] qx_s5, qy_s5;
	logic signed [CW:0]   ex_s5, ey_s5;
	logic [1:0]           rg_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s5 <= qx_c; qy_s5 <= qy_c; rg_s5 <= rg_s4;
			ex_s5 <= $signed({qx_c[CW-1], qx_c}) - $signed({px_s4[CW-1], px_s4});
			ey_s5 <= $signed({qy_c[CW-1], qy_c}) - $signed({py_s4[CW-1], py_s4});
		end
	end

	// squares registered, summed at the head of the root pipe
	logic signed [CW-1:0]   qx_s6, qy_s6;
	logic [2*CW+1:0]        sx_s6, sy_s6;
	logic [1:0]             rg_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s6 <= qx_s5; qy_s6 <= qy_s5; rg_s6 <= rg_s5;
			sx_s6 <= $unsigned((2*CW+2)'(ex_s5) * (2*CW+2)'(ex_s5));
			sy_s6 <= $unsigned((2*CW+2)'(ey_s5) * (2*CW+2)'(ey_s5));
		end
	end

	// square-root stages: one root bit per stage
	localparam int RW = 2*NSQ;
	typedef struct packed {
		logic signed [CW-1:0] qx, qy;
		logic [DSQ_WIDTH-1:0] dsq;
		logic [RW-1:0]        rem;
		logic [NSQ-1:0]       root;
		logic [1:0]           rg;
	} sq_t;
	sq_t sq_in;
	always_comb begin
		sq_in.qx = qx_s6; sq_in.qy = qy_s6; sq_in.rg = rg_s6;
		sq_in.dsq = DSQ_WIDTH'(sx_s6 + sy_s6);
		sq_in.rem = '0; sq_in.root = '0;
	end
	sq_t sq_q [NSQ-1];
	for (genvar k = 0; k < NSQ - 1; k++) begin : g_sqrt
		localparam int SH = 2*(NSQ-1-k);
		sq_t           src, nxt;
		logic [RW-1:0] pr, tr;
		if (k == 0) begin : g_head
			assign src = sq_in;
		end else begin : g_body
			assign src = sq_q[k-1];
		end
		assign pr = {src.rem[RW-3:0], 2'(RW'(src.dsq) >> SH)};
		assign tr = {src.root[NSQ-3:0], 2'b01} | (RW'(src.root) << 2);
		always_comb begin
			nxt = src;
			if (pr >= tr) begin
				nxt.rem  = pr - tr;
				nxt.root = {src.root[NSQ-2:0], 1'b1};
			end else begin
				nxt.rem  = pr;
				nxt.root = {src.root[NSQ-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_q[k] <= nxt;
			end
		end
	end

	// last root bit, into the output register
	sq_t           sl;
	logic [RW-1:0] prl, trl;
	assign sl  = sq_q[NSQ-2];
	assign prl = {sl.rem[RW-3:0], sl.dsq[1:0]};
	assign trl = RW'(sl.root) << 2 | RW'(1);
	logic [OUT_BYTES*8-1:0] out_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {4'b0, sl.rg, sl.root[NSQ-2:0], prl >= trl, sl.dsq, sl.qy, sl.qx};
		end
	end
	assign m_tdata = out_q;
endmodule

### hdl/pscd_checker.sv
// Port-level checks for the closest distance core, bound to the top level.
`timescale 1ns / 1ps
module pscd_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
	// input ready follows the output side
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stalled while empty");
	// root squared never exceeds the squared distance
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({16'b0, m_tdata[81:65]} * {16'b0, m_tdata[81:65]}) <= {1'b0, m_tdata[64:32]})
		else $error("root too large");
	// pad bits above the region stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:84] == 4'b0) else $error("pad bits set");
endmodule

bind point_segment_closest_distance_core pscd_port_checks u_pscd_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### verif/pscd_checker.sv
// Checker: predicts closest point, distance and root per transfer and compares results.
`timescale 1ns / 1ps
module pscd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [pscd_pkg::IN_BYTES*8-1:0]     s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [pscd_pkg::OUT_BYTES*8-1:0]    m_tdata,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  result_count,
	output int                                  interior_count
);
	import pscd_pkg::*;

	typedef struct {
		logic signed [15:0]     qx;
		logic signed [15:0]     qy;
		logic [DSQ_WIDTH-1:0]   dist_sq;
		logic [DRES_WIDTH-1:0]  dist_res;
		region_t                region;
	} closest_t;

	closest_t closest_q[$];

	// Floor square root, bit by bit.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 17; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Compute the closest point on segment A-B to P.
	function automatic closest_t closest_point(logic [IN_BYTES*8-1:0] d);
		longint ax, ay, bx, by, px, py, dx, dy, seg_len, proj, t, ex, ey;
		longint unsigned dsq;
		longint unsigned root_v;
		closest_t r;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		bx = longint'($signed(d[47:32]));
		by = longint'($signed(d[63:48]));
		px = longint'($signed(d[79:64]));
		py = longint'($signed(d[95:80]));
		dx = bx - ax;
		dy = by - ay;
		seg_len = dx * dx + dy * dy;
		proj = dx * (px - ax) + dy * (py - ay);
		if (seg_len == 0) begin
			ex = ax; ey = ay; r.region = REG_DEGEN;
		end else if (proj <= 0) begin
			ex = ax; ey = ay; r.region = REG_CLAMP_A;
		end else if (proj >= seg_len) begin
			ex = bx; ey = by; r.region = REG_CLAMP_B;
		end else begin
			t = (proj << 16) / seg_len;
			// Round half up: arithmetic shift floors.
			ex = ax + ((dx * t + 32768) >>> 16);
			ey = ay + ((dy * t + 32768) >>> 16);
			r.region = REG_INTERIOR;
		end
		r.qx = ex[15:0];
		r.qy = ey[15:0];
		dsq = longint'((ex - px) * (ex - px)) + longint'((ey - py) * (ey - py));
		r.dist_sq = dsq[DSQ_WIDTH-1:0];
		root_v = floor_root(dsq);
		r.dist_res = root_v[DRES_WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		interior_count = 0;
	end

	assign pending = closest_q.size();

	// Queue a prediction per input transfer; compare each output transfer.
	always @(posedge clk) begin
		closest_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				closest_q.push_back(closest_point(s_tdata));
			if (m_tvalid && m_tready) begin
				result_count++;
				if (closest_q.size() == 0) begin
					report_mismatch("unexpected result", 64'(m_tdata[63:0]), 64'd0);
				end else begin
					want = closest_q.pop_front();
					if (want.region == REG_INTERIOR)
						interior_count++;
					if (m_tdata[15:0] != want.qx)
						report_mismatch("qx", 64'(m_tdata[15:0]), 64'($unsigned(want.qx)));
					if (m_tdata[31:16] != want.qy)
						report_mismatch("qy", 64'(m_tdata[31:16]), 64'($unsigned(want.qy)));
					if (m_tdata[64:32] != want.dist_sq)
						report_mismatch("dist_sq", 64'(m_tdata[64:32]), 64'(want.dist_sq));
					if (m_tdata[81:65] != want.dist_res)
						report_mismatch("dist_res", 64'(m_tdata[81:65]), 64'(want.dist_res));
					if (m_tdata[83:82] != want.region)
						report_mismatch("region", 64'(m_tdata[83:82]), 64'(want.region));
				end
			end
		end
	end
endmodule

### verif/tb_point_segment_closest_distance_core.sv
// Testbench top: stimulus, flow control, watchdog and verdict for the closest distance core.
`timescale 1ns / 1ps
module tb_point_segment_closest_distance_core;
	import pscd_pkg::*;

	localparam int LATENCY     = 6 + 16 + 17;
	localparam int RANDOM_ITEMS = 450;
	localparam int STALL_LIMIT = 20000;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [IN_BYTES*8-1:0]      s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [OUT_BYTES*8-1:0]     m_tdata;
	int                         fail_count;
	int                         pending;
	int                         result_count;
	int                         interior_count;
	int                         idle_cycles;
	bit                         steady;
	int                         sent;

	point_segment_closest_distance_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	pscd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending),
		.result_count(result_count), .interior_count(interior_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Randomly stall the result side, except during steady stretches.
	always @(posedge clk)
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);

	// Count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", pending);
			$display("tb_point_segment_closest_distance_core failed");
			$finish;
		end
	end

	// Drive one transfer, with an optional random gap first.
	task automatic send_point(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by,
			logic signed [15:0] px, logic signed [15:0] py);
		while (!steady && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {py, px, by, bx, ay, ax};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [15:0] rand_coord(int span);
		int mode;
		mode = $urandom_range(9);
		if (mode == 0)
			return 16'($urandom());
		if (mode == 1)
			return $urandom_range(1) ? 16'h7fff : 16'h8000;
		return 16'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] ax, ay, bx, by, px, py;
		int span;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		steady   = 1'b0;
		sent     = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate, boundaries, interior rounding, full-range corners.
		send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, -16'sd7);
		send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_point(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd50);
		send_point(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd100, -16'sd50);
		send_point(16'sd0, 16'sd0, 16'sd100, 16'sd0, -16'sd20, 16'sd3);
		send_point(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd300, 16'sd3);
		send_point(16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, 16'sd9);
		send_point(16'sd0, 16'sd0, 16'sd3, 16'sd7, 16'sd1, 16'sd2);
		send_point(16'sd5, 16'sd5, -16'sd3, -16'sd7, 16'sd1, -16'sd2);
		send_point(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_point(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
		send_point(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		send_point(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
		send_point(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 16'hffff);
		send_point(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h1234, 16'h7fff);

		// Let every result out before the random part.
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 150 && i < 230);
			span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(300);
			ax = rand_coord(span);
			ay = rand_coord(span);
			bx = ($urandom_range(19) == 0) ? ax : rand_coord(span);
			by = ($urandom_range(19) == 0) ? ay : rand_coord(span);
			px = rand_coord(span);
			py = rand_coord(span);
			send_point(ax, ay, bx, by, px, py);
			if (i == 300)
				drain();
		end
		steady = 1'b0;
		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d segment queries, checked %0d results (%0d interior)",
			sent, result_count, interior_count);
		$display("covered degenerate, clamped and interior cases with random stalls");
		if (fail_count == 0)
			$display("tb_point_segment_closest_distance_core passed");
		else
			$display("tb_point_segment_closest_distance_core failed");
		$finish;
	end
endmodule
